FILE: hw/rtl/code_hash_linear_probe_table_macros.svh
// Assertion macros shared by the code hash table modules
`ifndef CODE_HASH_LINEAR_PROBE_TABLE_MACROS_SVH
`define CODE_HASH_LINEAR_PROBE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CHLP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("code hash table check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CHLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("code hash table check failed");

`endif

FILE: hw/rtl/chlp_pkg.sv
// Types and constants of the code hash table
package chlp_pkg;

	// Opcodes
	localparam logic OPC_INSERT = 1'b0;
	localparam logic OPC_SEARCH = 1'b1;

	// Key arithmetic: signed key, magnitude reduced by reciprocal multiply in three steps
	localparam int KEY_W     = 24;
	localparam int MOD_BITS  = KEY_W - 1;
	localparam int MOD_STEPS = 3;
	localparam int BCNT_W    = $clog2(MOD_STEPS);
	localparam logic signed [KEY_W-1:0] ALPHA1 = 24'sd26;
	localparam logic signed [KEY_W-1:0] ALPHA2 = 24'sd676;
	localparam logic signed [KEY_W-1:0] ALPHA3 = 24'sd17576;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD       = 2'd3
	} status_t;

	// One table slot as kept in memory
	typedef struct packed {
		logic        valid;
		logic [31:0] code;
		logic [15:0] offset;
	} entry_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_KEY,
		S_MOD,
		S_RD,
		S_CHK,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    load_key;
		logic    mod_step;
		logic    probe_start;
		logic    probe_next;
		logic    write_ins;
		logic    clr_write;
		logic    set_res;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic key_neg;
		logic mod_last;
		logic is_insert;
		logic slot_empty;
		logic slot_match;
		logic probe_last;
		logic clr_last;
	} stat_t;

endpackage

FILE: hw/rtl/chlp_ram.sv
// Generic single-write, single-read RAM with registered read data
module chlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/chlp_ctrl.sv
// Controller state machine of the code hash table
`include "code_hash_linear_probe_table_macros.svh"

module chlp_ctrl import chlp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register and output word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_KEY;
				end
			end
			S_KEY: begin
				cmd.load_key = 1'b1;
				state_d      = S_MOD;
			end
			S_MOD: begin
				if (stat.key_neg) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_BAD;
					state_d        = S_DONE;
				end else begin
					cmd.mod_step = 1'b1;
					if (stat.mod_last) begin
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.probe_start = 1'b1;
				state_d         = S_CHK;
			end
			S_CHK: begin
				if (stat.is_insert) begin
					if (stat.slot_empty) begin
						cmd.write_ins  = 1'b1;
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end else if (stat.probe_last) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_FULL;
						state_d        = S_DONE;
					end else begin
						cmd.probe_next = 1'b1;
					end
				end else begin
					if (stat.slot_empty || (!stat.slot_match && stat.probe_last)) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
						state_d        = S_DONE;
					end else if (stat.slot_match) begin
						cmd.set_res    = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end else begin
						cmd.probe_next = 1'b1;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result word that is still waiting
	`CHLP_ASSERT_NOW(a_out_load_free, cmd.out_load, !out_valid_q || out_ready)
	// A new result word only follows the done state
	`CHLP_ASSERT_NOW(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE))

endmodule

FILE: hw/rtl/chlp_dp.sv
// Datapath of the code hash table: key, modulo unit, probe pointer, slot memory
`include "code_hash_linear_probe_table_macros.svh"

module chlp_dp import chlp_pkg::*; #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               opcode,
	input  logic [7:0]         char_first,
	input  logic [7:0]         char_second,
	input  logic [7:0]         char_third,
	input  logic [7:0]         char_fourth,
	input  logic signed [15:0] offset_in,
	output logic [1:0]         status,
	output logic [9:0]         slot_index,
	output logic signed [15:0] offset_out
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam logic [SLOT_W:0]   SLOTS_N   = (SLOT_W + 1)'(TABLE_SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
	localparam logic [MOD_BITS-1:0] SLOTS_K = MOD_BITS'(TABLE_SLOTS);
	localparam logic [MOD_BITS-1:0] RECIP   = MOD_BITS'((1 << MOD_BITS) / TABLE_SLOTS);

	// Captured item
	logic               op_q;
	logic [31:0]        word_q;
	logic signed [15:0] off_in_q;

	// Key and modulo unit
	logic                 neg_q;
	logic [MOD_BITS-1:0]  kbits_q;
	logic [MOD_BITS-1:0]  quot_q;
	logic [SLOT_W:0]      rem_q;
	logic [BCNT_W-1:0]    bcnt_q;

	// Probe pointer and count
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] cnt_q;

	// Result and output words
	status_t            res_status_q, out_status_q;
	logic [SLOT_W-1:0]  res_idx_q, out_idx_q;
	logic signed [15:0] res_off_q, out_off_q;

	logic [31:0]             word_c;
	logic signed [KEY_W-1:0] key_c;
	logic [2*MOD_BITS-1:0]   prod_c;
	logic [MOD_BITS-1:0]     diff_c;
	logic [SLOT_W-1:0]       rem_nxt;
	logic [SLOT_W-1:0]       slot_nxt;
	logic                    ram_we;
	logic [SLOT_W-1:0]       ram_raddr;
	entry_t                  ram_wdata, rd_entry;

	function automatic logic signed [KEY_W-1:0] letter_pos(input logic [7:0] c,
			input logic signed [9:0] base);
		logic signed [9:0] p;
		p = $signed({2'b00, c}) - base;
		return $signed({{(KEY_W - 10){p[9]}}, p});
	endfunction

	// Drop bytes after the first zero byte
	always_comb begin
		word_c[7:0]   = char_first;
		word_c[15:8]  = (char_first != 8'd0) ? char_second : 8'd0;
		word_c[23:16] = (char_first != 8'd0 && char_second != 8'd0) ? char_third : 8'd0;
		word_c[31:24] = (char_first != 8'd0 && char_second != 8'd0 && char_third != 8'd0)
			? char_fourth : 8'd0;
	end

	// Base-26 key of the captured code
	always_comb begin
		if (word_q[31:24] != 8'd0) begin
			key_c = letter_pos(word_q[7:0], 10'sd64) * ALPHA3
				+ letter_pos(word_q[15:8], 10'sd65) * ALPHA2
				+ letter_pos(word_q[23:16], 10'sd65) * ALPHA1
				+ letter_pos(word_q[31:24], 10'sd65);
		end else begin
			key_c = letter_pos(word_q[7:0], 10'sd65) * ALPHA2
				+ letter_pos(word_q[15:8], 10'sd65) * ALPHA1
				+ letter_pos(word_q[23:16], 10'sd65);
		end
	end

	// Key modulo slot count: quotient estimate, remainder below twice the count, one correction
	always_comb begin
		prod_c = (2*MOD_BITS)'(kbits_q) * (2*MOD_BITS)'(RECIP);
		diff_c = kbits_q - quot_q * SLOTS_K;
		if (rem_q >= SLOTS_N) begin
			rem_nxt = SLOT_W'(rem_q - SLOTS_N);
		end else begin
			rem_nxt = SLOT_W'(rem_q);
		end
	end

	// Advance pointer with wrap at the table end
	assign slot_nxt = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= opcode;
			word_q   <= word_c;
			off_in_q <= offset_in;
		end
	end

	// Key, modulo unit and probe registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= 1'b0;
			kbits_q <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			bcnt_q  <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.load_key) begin
				neg_q   <= key_c[KEY_W-1];
				kbits_q <= key_c[MOD_BITS-1:0];
				rem_q   <= '0;
				bcnt_q  <= '0;
			end
			if (cmd.mod_step) begin
				quot_q <= prod_c[2*MOD_BITS-1:MOD_BITS];
				rem_q  <= diff_c[SLOT_W:0];
				bcnt_q <= bcnt_q + BCNT_W'(1);
				if (stat.mod_last) begin
					slot_q <= rem_nxt;
				end
			end
			if (cmd.probe_start) begin
				cnt_q <= '0;
			end
			if (cmd.probe_next) begin
				slot_q <= slot_nxt;
				cnt_q  <= cnt_q + SLOT_W'(1);
			end
			if (cmd.clr_write) begin
				slot_q <= slot_nxt;
			end
		end
	end

	// Hold result, then move it to the output word
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_idx_q    <= (cmd.res_status == ST_OK) ? slot_q : '0;
			res_off_q    <= (cmd.res_status == ST_OK && op_q == OPC_SEARCH)
				? $signed(rd_entry.offset) : 16'sd0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_off_q    <= res_off_q;
		end
	end

	// Slot memory access
	always_comb begin
		ram_we    = cmd.clr_write || cmd.write_ins;
		ram_wdata = '0;
		if (cmd.write_ins) begin
			ram_wdata.valid  = 1'b1;
			ram_wdata.code   = word_q;
			ram_wdata.offset = off_in_q;
		end
		ram_raddr = cmd.probe_next ? slot_nxt : slot_q;
	end

	chlp_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_entry)
	);

	// Status to controller
	always_comb begin
		stat.key_neg    = neg_q;
		stat.mod_last   = (bcnt_q == BCNT_W'(MOD_STEPS - 1));
		stat.is_insert  = (op_q == OPC_INSERT);
		stat.slot_empty = !rd_entry.valid;
		stat.slot_match = (rd_entry.code == word_q);
		stat.probe_last = (cnt_q == SLOT_LAST);
		stat.clr_last   = (slot_q == SLOT_LAST);
	end

	assign status     = out_status_q;
	assign slot_index = 10'(out_idx_q);
	assign offset_out = out_off_q;

	// Insert only ever fills an empty slot
	`CHLP_ASSERT_NOW(a_insert_empty, cmd.write_ins, !rd_entry.valid)
	// Probing never goes past one full lap of the table
	`CHLP_ASSERT_NOW(a_probe_lap, cmd.probe_next, cnt_q != SLOT_LAST)

endmodule

FILE: hw/rtl/code_hash_linear_probe_table.sv
// An accepted word is captured, its key is formed and reduced modulo the slot count,
// and the table is then probed from the home slot; a code with a negative key answers ST_BAD.
// Items are taken one at a time; the pace is set by the 3-step modulo unit
// and the one-slot-per-cycle probe over the slot memory's single read port.
// Reset: a clearing pass marks every slot empty; in_ready is low until it ends.
module code_hash_linear_probe_table import chlp_pkg::*; #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         char_first,
	input  logic [7:0]         char_second,
	input  logic [7:0]         char_third,
	input  logic [7:0]         char_fourth,
	input  logic signed [15:0] offset_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [9:0]         slot_index,
	output logic signed [15:0] offset_out
);

	cmd_t  cmd;
	stat_t stat;

	chlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	chlp_dp #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.opcode     (opcode),
		.char_first (char_first),
		.char_second(char_second),
		.char_third (char_third),
		.char_fourth(char_fourth),
		.offset_in  (offset_in),
		.status     (status),
		.slot_index (slot_index),
		.offset_out (offset_out)
	);

endmodule

FILE: tb/code_hash_table_checker.sv
// Checker for the code hash table: watches both channels, predicts each answer, compares
module code_hash_table_checker import chlp_pkg::*; #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         char_first,
	input  logic [7:0]         char_second,
	input  logic [7:0]         char_third,
	input  logic [7:0]         char_fourth,
	input  logic signed [15:0] offset_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [9:0]         slot_index,
	input  logic signed [15:0] offset_out,
	output int                 fail_count,
	output int                 pending_words,
	output int                 filled_slots
);

	localparam int LETTER_BASE = 65;
	localparam int ALPHA       = 26;

	typedef struct packed {
		status_t            status;
		logic [9:0]         slot;
		logic signed [15:0] offset;
	} answer_t;

	// Shadow copy of the table
	logic               occupied      [TABLE_SLOTS];
	logic [31:0]        stored_code   [TABLE_SLOTS];
	logic signed [15:0] stored_offset [TABLE_SLOTS];

	answer_t answer_q [$];
	answer_t awaited;
	int      fails;
	int      used;

	// Letter position, bytes taken as unsigned
	function automatic int letter_pos(input int c);
		return c - LETTER_BASE;
	endfunction

	// Hash the code, probe the shadow table, update it on insert
	function automatic answer_t probe_table(input logic op, input logic [31:0] raw,
			input logic signed [15:0] off);
		answer_t     ans;
		logic [31:0] word;
		logic        ended;
		int          key;
		int          slot;
		ans = '{status: ST_NOT_FOUND, slot: '0, offset: '0};
		word = '0;
		ended = 1'b0;
		// zero the bytes after the first zero byte
		for (int i = 0; i < 4; i++) begin
			if (raw[8*i +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				word[8*i +: 8] = raw[8*i +: 8];
		end
		if (word[31:24] == 8'd0) begin
			key = letter_pos(int'(word[7:0])) * ALPHA * ALPHA
				+ letter_pos(int'(word[15:8])) * ALPHA
				+ letter_pos(int'(word[23:16]));
		end else begin
			key = letter_pos(int'(word[7:0]) + 1) * ALPHA * ALPHA * ALPHA
				+ letter_pos(int'(word[15:8])) * ALPHA * ALPHA
				+ letter_pos(int'(word[23:16])) * ALPHA
				+ letter_pos(int'(word[31:24]));
		end
		if (key < 0) begin
			ans.status = ST_BAD;
		end else begin
			slot = key % TABLE_SLOTS;
			if (op == OPC_INSERT) begin
				ans.status = ST_FULL;
				for (int n = 0; n < TABLE_SLOTS; n++) begin
					if (!occupied[slot]) begin
						occupied[slot] = 1'b1;
						stored_code[slot] = word;
						stored_offset[slot] = off;
						used++;
						ans.status = ST_OK;
						ans.slot = 10'(slot);
						break;
					end
					slot = (slot + 1) % TABLE_SLOTS;
				end
			end else begin
				for (int n = 0; n < TABLE_SLOTS; n++) begin
					if (!occupied[slot])
						break;
					if (stored_code[slot] == word) begin
						ans.status = ST_OK;
						ans.slot = 10'(slot);
						ans.offset = stored_offset[slot];
						break;
					end
					slot = (slot + 1) % TABLE_SLOTS;
				end
			end
		end
		return ans;
	endfunction

	// Compare result words, then queue the answer of each accepted input word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				occupied[i] = 1'b0;
			answer_q.delete();
			fails = 0;
			used = 0;
			fail_count <= 0;
			pending_words <= 0;
			filled_slots <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					$error("result word with no answer pending");
					fails++;
				end else begin
					awaited = answer_q.pop_front();
					if (status !== awaited.status) begin
						$error("status: expected %0d, got %0d", awaited.status, status);
						fails++;
					end
					if (slot_index !== awaited.slot) begin
						$error("slot_index: expected %0d, got %0d", awaited.slot, slot_index);
						fails++;
					end
					if (offset_out !== awaited.offset) begin
						$error("offset_out: expected %0d, got %0d", awaited.offset,
							offset_out);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				answer_q.push_back(probe_table(opcode,
					{char_fourth, char_third, char_second, char_first}, offset_in));
			fail_count <= fails;
			pending_words <= answer_q.size();
			filled_slots <= used;
		end
	end

endmodule

FILE: tb/tb_code_hash_linear_probe_table.sv
// Testbench top for the code hash table: stimulus, flow control and verdict
module tb_code_hash_linear_probe_table import chlp_pkg::*;;

	localparam int TABLE_SLOTS = 1024;
	localparam int PHASE_WORDS = 225;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               opcode      = OPC_INSERT;
	logic [7:0]         char_first  = 8'd0;
	logic [7:0]         char_second = 8'd0;
	logic [7:0]         char_third  = 8'd0;
	logic [7:0]         char_fourth = 8'd0;
	logic signed [15:0] offset_in   = 16'sd0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [1:0]         status;
	logic [9:0]         slot_index;
	logic signed [15:0] offset_out;

	int fail_count;
	int pending_words;
	int filled_slots;

	int idle_pct  = 0;
	int stall_pct = 0;

	// Codes placed by well-formed inserts, drawn on for search hits
	logic [31:0] placed_codes [$];

	always #1 clk = ~clk;

	code_hash_linear_probe_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.char_first (char_first),
		.char_second(char_second),
		.char_third (char_third),
		.char_fourth(char_fourth),
		.offset_in  (offset_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index),
		.offset_out (offset_out)
	);

	code_hash_table_checker #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.char_first   (char_first),
		.char_second  (char_second),
		.char_third   (char_third),
		.char_fourth  (char_fourth),
		.offset_in    (offset_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_index   (slot_index),
		.offset_out   (offset_out),
		.fail_count   (fail_count),
		.pending_words(pending_words),
		.filled_slots (filled_slots)
	);

	// Stall the result channel at random
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// Pack four bytes, first letter in the low byte
	function automatic logic [31:0] code4(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3);
		return {c3, c2, c1, c0};
	endfunction

	// Random well-formed code of three or four capital letters
	function automatic logic [31:0] rand_code();
		logic [31:0] w;
		w[7:0]   = 8'(65 + $urandom_range(0, 25));
		w[15:8]  = 8'(65 + $urandom_range(0, 25));
		w[23:16] = 8'(65 + $urandom_range(0, 25));
		w[31:24] = $urandom_range(0, 1) ? 8'(65 + $urandom_range(0, 25)) : 8'd0;
		return w;
	endfunction

	// Three-letter code whose key lands on the given home slot
	function automatic logic [31:0] code_for_slot(input int s);
		int key;
		key = s + TABLE_SLOTS * $urandom_range(0, 16);
		return code4(8'(65 + key / 676), 8'(65 + (key / 26) % 26), 8'(65 + key % 26), 8'd0);
	endfunction

	// Present one word, holding it until accepted; call at a rising edge
	task automatic send_word(input logic op, input logic [31:0] code,
			input logic signed [15:0] off);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		char_first <= code[7:0];
		char_second <= code[15:8];
		char_third <= code[23:16];
		char_fourth <= code[31:24];
		offset_in <= off;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold until every answer has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed inserts and searches, some raw byte noise
	task automatic random_item();
		int          pick;
		logic [31:0] code;
		logic signed [15:0] off;
		pick = $urandom_range(0, 99);
		off = 16'($urandom_range(0, 65535));
		if (pick < 30 || (pick < 70 && placed_codes.size() == 0)) begin
			code = rand_code();
			placed_codes.push_back(code);
			send_word(OPC_INSERT, code, off);
		end else if (pick < 40) begin
			// duplicate insert of a code already placed
			send_word(OPC_INSERT, placed_codes[$urandom_range(0, placed_codes.size() - 1)], off);
		end else if (pick < 70) begin
			send_word(OPC_SEARCH, placed_codes[$urandom_range(0, placed_codes.size() - 1)], off);
		end else if (pick < 82) begin
			send_word(OPC_SEARCH, rand_code(), off);
		end else begin
			for (int i = 0; i < 4; i++)
				code[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
			send_word(logic'($urandom_range(0, 1)), code, off);
		end
	endtask

	// Run limit
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		int idle_by_phase  [4];
		int stall_by_phase [4];
		int s;
		idle_by_phase = '{0, 84, 0, 19};
		stall_by_phase = '{0, 0, 84, 19};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, collisions, bad keys, embedded zero
		send_word(OPC_INSERT, code4("A", "B", "C", 8'd0), 16'sh7FFF);
		send_word(OPC_SEARCH, code4("A", "B", "C", 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("A", "B", "C", 8'd0), 16'sh8000);
		send_word(OPC_SEARCH, code4("A", "B", "C", 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("A", "A", "A", 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("Z", "Z", "Z", "Z"), -16'sd1);
		send_word(OPC_SEARCH, code4("Z", "Z", "Z", "Z"), 16'sd0);
		send_word(OPC_SEARCH, code4("X", "Y", "Z", 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("@", "A", "B", "C"), 16'sd1234);
		send_word(OPC_SEARCH, code4("@", "A", "B", "C"), 16'sd0);
		send_word(OPC_INSERT, code4("@", "A", "A", 8'd0), 16'sd7);
		send_word(OPC_SEARCH, code4(8'd0, 8'd0, 8'd0, 8'd0), 16'sd0);
		send_word(OPC_SEARCH, code4("A", 8'd0, 8'd0, 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("C", "B", 8'd0, "Q"), 16'sh0F0F);
		send_word(OPC_SEARCH, code4("C", "B", 8'd0, "X"), 16'sd0);
		send_word(OPC_INSERT, code4(8'hFF, 8'hFF, 8'hFF, 8'hFF), 16'sh5A5A);
		send_word(OPC_SEARCH, code4(8'hFF, 8'hFF, 8'hFF, 8'hFF), 16'sd0);
		send_word(OPC_INSERT, code4("Z", "Z", "Z", 8'd0), 16'sh5555);
		send_word(OPC_SEARCH, code4("Z", "Z", "Z", 8'd0), 16'sd0);
		send_word(OPC_INSERT, code4("B", "N", "F", 8'd0), 16'sd11);
		send_word(OPC_INSERT, code4("B", "N", "F", 8'd0), 16'sd22);
		send_word(OPC_SEARCH, code4("B", "N", "F", 8'd0), 16'sd0);
		send_word(OPC_SEARCH, code4("A", "A", "B", 8'd0), 16'sd0);
		wait_drained();

		// random phases with different flow control, drained in between
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			for (int k = 0; k < PHASE_WORDS; k++)
				random_item();
			wait_drained();
		end

		// fill the table one home slot at a time, each insert answered before the next
		idle_pct = 0;
		stall_pct = 0;
		s = 0;
		while (filled_slots < TABLE_SLOTS) begin
			send_word(OPC_INSERT, code_for_slot(s % TABLE_SLOTS), 16'($urandom_range(0, 65535)));
			wait_drained();
			s++;
		end

		// full table: insert refused, searches hit or run the whole table
		stall_pct = 84;
		send_word(OPC_INSERT, rand_code(), 16'sd99);
		send_word(OPC_SEARCH, placed_codes[$urandom_range(0, placed_codes.size() - 1)], 16'sd0);
		send_word(OPC_SEARCH, rand_code(), 16'sd0);
		send_word(OPC_SEARCH, code4(8'hFF, 8'hFE, 8'hFD, 8'hFC), 16'sd0);
		send_word(OPC_INSERT, code4("@", "@", "@", 8'd0), 16'sd0);
		wait_drained();
		repeat (64) @(posedge clk);

		if (fail_count == 0 && pending_words == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
